// File: src/rua_pkg.sv
// Shared types for the rectangle union area block.
package rua_pkg;

	// Sequencer states of the grid walker.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} rua_state_t;

	// Control from the walker to the update stage and the grid memory.
	typedef struct packed {
		logic rd_en;      // read one grid cell at the walker address
		logic clr_wr;     // write a clear cell at the walker address
		logic clr_count;  // zero the covered count
		logic finish;     // the count is final for this beat
	} rua_cmd_t;

	// Widths fixed by the item fields.
	localparam int CoordWidth = 8;
	localparam int AreaWidth  = 15;
	localparam logic [AreaWidth-1:0] AreaMax = '1;

endpackage

// File: src/rua_grid_ram.sv
// Occupancy grid storage: one bit per cell, one write and one registered read port.
module rua_grid_ram #(
	parameter int GRID_SIZE = 128
) (
	input  logic                                 clk,
	input  logic                                 rd_en,
	input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] rd_addr,
	output logic                                 rd_data,
	input  logic                                 wr_en,
	input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] wr_addr,
	input  logic                                 wr_data
);
	localparam int Depth = GRID_SIZE * GRID_SIZE;

	logic mem [Depth];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: src/rua_walker.sv
// Grid walker: clears the grid and steps through the cells of each rectangle.
module rua_walker #(
	parameter int GRID_SIZE = 128
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   first_of_set,
	input  logic [rua_pkg::CoordWidth-1:0]         x_low,
	input  logic [rua_pkg::CoordWidth-1:0]         y_low,
	input  logic [rua_pkg::CoordWidth-1:0]         x_high,
	input  logic [rua_pkg::CoordWidth-1:0]         y_high,
	output rua_pkg::rua_cmd_t                      cmd,
	output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] mem_addr
);
	import rua_pkg::*;

	localparam int CW = $clog2(GRID_SIZE + 1);
	localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);
	localparam logic [AW-1:0] LastAddr = AW'(GRID_SIZE * GRID_SIZE - 1);
	localparam logic [AW-1:0] RowStep  = AW'(GRID_SIZE);

	rua_state_t state_q, state_d;

	logic [CW-1:0] x_q, y_q, yl_q, xh_q, yh_q;
	logic [AW-1:0] row_base_q, clr_q;
	logic          pend_q;
	logic [CW-1:0] y_next;
	logic          row_end, last_row, accept;

	// Coordinates above the grid edge saturate to the grid size.
	function automatic logic [CW-1:0] clamp(input logic [CoordWidth-1:0] v);
		if (int'(v) > GRID_SIZE) begin
			return CW'(GRID_SIZE);
		end
		return CW'(v);
	endfunction

	assign accept   = start && !busy;
	assign y_next   = y_q + CW'(1);
	assign row_end  = (y_next == yh_q);
	assign last_row = ((x_q + CW'(1)) == xh_q);

	// State register; reset starts a clearing pass over the grid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control outputs.
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		busy          = 1'b1;
		mem_addr      = clr_q;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.clr_count = first_of_set;
					state_d       = first_of_set ? ST_CLEAR : ST_SETUP;
				end
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (clr_q == LastAddr) begin
					state_d = pend_q ? ST_SETUP : ST_IDLE;
				end
			end
			ST_SETUP: begin
				if ((xh_q > x_q) && (yh_q > y_q)) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				mem_addr  = row_base_q + AW'(y_q);
				if (row_end && last_row) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control flags: an item waits behind a clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			clr_q  <= '0;
		end else begin
			if (accept) begin
				pend_q <= 1'b1;
				clr_q  <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// Rectangle registers and the cell counters.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= clamp(x_low);
			y_q     <= clamp(y_low);
			yl_q    <= clamp(y_low);
			xh_q    <= clamp(x_high);
			yh_q    <= clamp(y_high);
		end else if (state_q == ST_SETUP) begin
			row_base_q <= AW'(int'(x_q) * GRID_SIZE);
		end else if (state_q == ST_SCAN) begin
			if (row_end) begin
				y_q        <= yl_q;
				x_q        <= x_q + CW'(1);
				row_base_q <= row_base_q + RowStep;
			end else begin
				y_q <= y_next;
			end
		end
	end

endmodule

// File: src/rectangle_union_area.sv
// Sequence: setup, then for a non-empty rectangle a read of each cell and a drain state, then the done strobe;
// an item with first_of_set first waits for the clearing pass of the whole grid.
// One item at a time: busy stays high through the single read-modify-write walk of the grid.
// Reset: asynchronous; afterwards busy stays high for a clearing pass of the grid
// memory, and the covered count starts at zero.
// The receiver cannot stall: each result is shown for one cycle under done.
module rectangle_union_area #(
	parameter int GRID_SIZE = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           first_of_set,
	input  logic [rua_pkg::CoordWidth-1:0] x_low,
	input  logic [rua_pkg::CoordWidth-1:0] y_low,
	input  logic [rua_pkg::CoordWidth-1:0] x_high,
	input  logic [rua_pkg::CoordWidth-1:0] y_high,
	output logic                           done,
	output logic [rua_pkg::AreaWidth-1:0]  union_area
);
	import rua_pkg::*;

	localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);

	rua_cmd_t             cmd;
	logic [AW-1:0]        mem_addr, addr_s1, wr_addr;
	logic                 valid_s1, rd_data, wr_en, wr_data;
	logic [AreaWidth-1:0] count_q;

	rua_walker #(
		.GRID_SIZE(GRID_SIZE)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.first_of_set(first_of_set),
		.x_low       (x_low),
		.y_low       (y_low),
		.x_high      (x_high),
		.y_high      (y_high),
		.cmd         (cmd),
		.mem_addr    (mem_addr)
	);

	// The clearing pass and the update stage never write in the same cycle.
	assign wr_en   = cmd.clr_wr || valid_s1;
	assign wr_addr = cmd.clr_wr ? mem_addr : addr_s1;
	assign wr_data = !cmd.clr_wr;

	rua_grid_ram #(
		.GRID_SIZE(GRID_SIZE)
	) u_grid (
		.clk    (clk),
		.rd_en  (cmd.rd_en),
		.rd_addr(mem_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// Update stage: the cell read last cycle is marked and counted if it was clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= mem_addr;
	end

	// Covered count, saturating at the largest area value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clr_count) begin
			count_q <= '0;
		end else if (valid_s1 && !rd_data && (count_q < AreaMax)) begin
			count_q <= count_q + AreaWidth'(1);
		end
	end

	assign done       = cmd.finish;
	assign union_area = count_q;

	// A cell update must never collide with the clearing pass.
	assert property (@(posedge clk) disable iff (!arst_n) !(valid_s1 && cmd.clr_wr))
		else $error("cell update overlaps grid clearing");

	// The count only falls when a new set begins.
	assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.clr_count |=> count_q >= $past(count_q))
		else $error("covered count decreased without a clear");

	// An accepted beat holds the block busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("busy did not rise after accept");

	// A result strobe lasts exactly one cycle.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held for more than one cycle");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the rectangle union area block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rua_pkg::*;

	localparam int GRID       = 128;
	localparam int CELLS      = GRID * GRID;
	localparam int N_DIR      = 21;
	localparam int PHASE_LEN  = 27;
	localparam int N_PHASES   = 3;
	localparam int MAX_GAP    = 40;
	localparam int TAIL_WAIT  = 40;
	// Slowest correct run: the clearing pass after reset, then every item clearing the
	// grid, walking all of it and waiting out the longest gap, taken three times over.
	localparam int CYCLE_LIMIT =
		3 * (CELLS + (N_DIR + N_PHASES * PHASE_LEN) * (2 * CELLS + MAX_GAP + 40));

	// One row of the directed table; typed marks an area that is known at a glance.
	typedef struct packed {
		logic                  fos;
		logic [CoordWidth-1:0] xl;
		logic [CoordWidth-1:0] yl;
		logic [CoordWidth-1:0] xh;
		logic [CoordWidth-1:0] yh;
		logic                  typed;
		logic [AreaWidth-1:0]  area;
	} rect_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  first_of_set = 1'b0;
	logic [CoordWidth-1:0] x_low = '0;
	logic [CoordWidth-1:0] y_low = '0;
	logic [CoordWidth-1:0] x_high = '0;
	logic [CoordWidth-1:0] y_high = '0;
	logic                  done;
	logic [AreaWidth-1:0]  union_area;

	// Predictor state: the occupancy map and the union area of the current set.
	logic                  occ_map [CELLS];
	logic [AreaWidth-1:0]  covered_cells = '0;
	logic [AreaWidth-1:0]  pending_areas [$];
	int                    fail_count = 0;
	int                    cycle_count = 0;

	rect_row_t dir_rows [N_DIR] = '{
		// Reset state: an empty rectangle before any set is started.
		'{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 15'd0},
		'{1'b0, 8'd0,   8'd0,   8'd1,   8'd1,   1'b1, 15'd1},
		'{1'b0, 8'd127, 8'd127, 8'd128, 8'd128, 1'b1, 15'd2},
		'{1'b0, 8'd0,   8'd0,   8'd1,   8'd1,   1'b1, 15'd2},
		// Full grid after a clear, then a rectangle already covered.
		'{1'b1, 8'd0,   8'd0,   8'd128, 8'd128, 1'b1, 15'd16384},
		'{1'b0, 8'd10,  8'd10,  8'd20,  8'd20,  1'b1, 15'd16384},
		// Empty and inverted rectangles.
		'{1'b1, 8'd5,   8'd5,   8'd5,   8'd9,   1'b1, 15'd0},
		'{1'b0, 8'd9,   8'd3,   8'd4,   8'd7,   1'b1, 15'd0},
		'{1'b0, 8'd3,   8'd7,   8'd9,   8'd2,   1'b1, 15'd0},
		// Coordinates beyond the grid saturate to its edge.
		'{1'b0, 8'd200, 8'd200, 8'd255, 8'd255, 1'b1, 15'd0},
		'{1'b0, 8'd120, 8'd0,   8'd255, 8'd1,   1'b1, 15'd8},
		'{1'b0, 8'd0,   8'd120, 8'd1,   8'd255, 1'b1, 15'd16},
		'{1'b0, 8'd100, 8'd100, 8'd110, 8'd105, 1'b1, 15'd66},
		'{1'b0, 8'd105, 8'd102, 8'd115, 8'd108, 1'b0, 15'd0},
		'{1'b1, 8'd0,   8'd0,   8'd255, 8'd255, 1'b1, 15'd16384},
		'{1'b1, 8'd1,   8'd2,   8'd4,   8'd8,   1'b1, 15'd18},
		'{1'b0, 8'h55,  8'h55,  8'hAA,  8'hAA,  1'b0, 15'd0},
		'{1'b0, 8'd0,   8'd0,   8'd127, 8'd1,   1'b0, 15'd0},
		'{1'b0, 8'd64,  8'd0,   8'd65,  8'd128, 1'b0, 15'd0},
		'{1'b1, 8'd127, 8'd0,   8'd128, 8'd128, 1'b1, 15'd128},
		'{1'b0, 8'd0,   8'd127, 8'd128, 8'd128, 1'b1, 15'd255}
	};

	rectangle_union_area #(
		.GRID_SIZE(GRID)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.first_of_set(first_of_set),
		.x_low       (x_low),
		.y_low       (y_low),
		.x_high      (x_high),
		.y_high      (y_high),
		.done        (done),
		.union_area  (union_area)
	);

	always #6 clk = ~clk;

	// Count a failure and report the first few of them.
	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Limit a coordinate to the grid edge.
	function automatic int sat_coord(input logic [CoordWidth-1:0] v);
		return (int'(v) > GRID) ? GRID : int'(v);
	endfunction

	// Mark the rectangle in the occupancy map and return the new union area.
	task automatic draw_rect(input logic fos, input logic [CoordWidth-1:0] xl,
			input logic [CoordWidth-1:0] yl, input logic [CoordWidth-1:0] xh,
			input logic [CoordWidth-1:0] yh, output logic [AreaWidth-1:0] area);
		int x0, y0, x1, y1;
		x0 = sat_coord(xl);
		y0 = sat_coord(yl);
		x1 = sat_coord(xh);
		y1 = sat_coord(yh);
		if (fos) begin
			foreach (occ_map[i]) occ_map[i] = 1'b0;
			covered_cells = '0;
		end
		for (int x = x0; x < x1; x++) begin
			for (int y = y0; y < y1; y++) begin
				if (!occ_map[x * GRID + y]) begin
					occ_map[x * GRID + y] = 1'b1;
					if (covered_cells != AreaMax) covered_cells++;
				end
			end
		end
		area = covered_cells;
	endtask

	// Idle cycles before the next beat, drawn against an idle percentage.
	function automatic int pick_gap(input int pct);
		if (pct > 0 && $urandom_range(99) < pct) return $urandom_range(1, MAX_GAP);
		return 0;
	endfunction

	// Offer one rectangle after a gap and wait until the block takes it.
	// Returns in the time step of the accepting edge with start still high.
	task automatic send_rect(input logic fos, input logic [CoordWidth-1:0] xl,
			input logic [CoordWidth-1:0] yl, input logic [CoordWidth-1:0] xh,
			input logic [CoordWidth-1:0] yh, input int gap, input logic typed,
			input logic [AreaWidth-1:0] typed_area);
		logic [AreaWidth-1:0] area;
		for (int i = 0; i < gap; i++) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		first_of_set <= fos;
		x_low        <= xl;
		y_low        <= yl;
		x_high       <= xh;
		y_high       <= yh;
		@(posedge clk);
		while (busy) @(posedge clk);
		draw_rect(fos, xl, yl, xh, yh, area);
		pending_areas.push_back(typed ? typed_area : area);
	endtask

	// Park the sender until every expected area has come back.
	task automatic drain_areas();
		start <= 1'b0;
		while (pending_areas.size() != 0) @(posedge clk);
	endtask

	// Result checker: every done beat is matched against the oldest expected area.
	always @(posedge clk) begin : check_area
		logic [AreaWidth-1:0] want;
		if (arst_n && done) begin
			if (pending_areas.size() == 0) begin
				note_failure($sformatf("unexpected result: union_area=%0d", union_area));
			end else begin
				want = pending_areas.pop_front();
				if (union_area !== want) begin
					note_failure($sformatf("union_area mismatch: expected %0d, got %0d",
						want, union_area));
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stimulus: directed table first, then random phases with different idle rates.
	initial begin : stimulus
		int                    phase_pct [N_PHASES];
		int                    bx, by, r;
		logic                  fos;
		logic [CoordWidth-1:0] xl, yl, xh, yh;
		phase_pct = '{0, 54, 35};
		bx = 0;
		by = 0;
		foreach (occ_map[i]) occ_map[i] = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			send_rect(dir_rows[i].fos, dir_rows[i].xl, dir_rows[i].yl, dir_rows[i].xh,
				dir_rows[i].yh, (i < 10) ? 0 : pick_gap(54), dir_rows[i].typed,
				dir_rows[i].area);
		end
		drain_areas();

		// Random sets: clustered small rectangles so they overlap, a few large or
		// arbitrary ones, and rectangles hanging over the grid edge.
		for (int p = 0; p < N_PHASES; p++) begin
			for (int k = 0; k < PHASE_LEN; k++) begin
				fos = ($urandom_range(99) < 8);
				if (fos) begin
					bx = $urandom_range(0, GRID - 1);
					by = $urandom_range(0, GRID - 1);
				end
				r = $urandom_range(99);
				if (r < 6) begin
					xl = CoordWidth'($urandom_range(0, 255));
					yl = CoordWidth'($urandom_range(0, 255));
					xh = CoordWidth'($urandom_range(0, 255));
					yh = CoordWidth'($urandom_range(0, 255));
				end else if (r < 14) begin
					xl = CoordWidth'($urandom_range(GRID - 8, 255));
					yl = CoordWidth'($urandom_range(0, GRID - 1));
					xh = CoordWidth'($urandom_range(GRID - 8, 255));
					yh = CoordWidth'(int'(yl) + $urandom_range(0, 10));
				end else begin
					xl = CoordWidth'(bx + $urandom_range(0, 15));
					yl = CoordWidth'(by + $urandom_range(0, 15));
					xh = CoordWidth'(int'(xl) + $urandom_range(0, 12));
					yh = CoordWidth'(int'(yl) + $urandom_range(0, 12));
				end
				send_rect(fos, xl, yl, xh, yh, pick_gap(phase_pct[p]), 1'b0, '0);
			end
			drain_areas();
		end

		// Let any stray result show up before judging the run.
		repeat (TAIL_WAIT) @(posedge clk);
		if (fail_count == 0 && pending_areas.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
